// ===== hdl/tmcw_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Text console writer: shared definitions
// Field widths, character codes, the microcode format and the control store
// that sequences every item through the datapath.
// ---------------------------------------------------------------------------
package tmcw_pkg;

  localparam int DEF_COLUMNS  = 80;
  localparam int DEF_ROWS     = 25;
  localparam int DEF_TAB_STEP = 8;

  localparam int CHAR_W      = 8;
  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 7;
  localparam int CELL_W      = 16;
  localparam int TEXT_W      = 4;
  localparam int BACK_W      = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 4;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_HT    = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'd12;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [CELL_W-1:0] CELL_RESET = 16'h0F20;
  localparam logic [TEXT_W-1:0] TEXT_RESET = 4'd15;
  localparam logic [BACK_W-1:0] BACK_RESET = 3'd0;

  localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_COLOR = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BACK_COLOR = 1'd1;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Item classes; the order matches the dispatch table in the control store.
  typedef enum logic [2:0] {
    CLS_READ,
    CLS_BS,
    CLS_TAB,
    CLS_LF,
    CLS_FF,
    CLS_CR,
    CLS_GLYPH
  } cls_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_RESET_INIT,
    ACT_FILL,
    ACT_TAKE,
    ACT_RD_ISSUE,
    ACT_RD_CAPTURE,
    ACT_BS,
    ACT_CR,
    ACT_TAB_SET,
    ACT_GLYPH,
    ACT_LINE_DOWN,
    ACT_SCROLL_INIT,
    ACT_FF_INIT,
    ACT_EMIT
  } act_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_SWEEP_MORE,
    COND_DISPATCH,
    COND_TAB_FITS,
    COND_COL_WRAP,
    COND_ROW_NOT_LAST
  } cond_t;

  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t S_RST_INIT    = 5'd0;
  localparam upc_t S_RST_FILL    = 5'd1;
  localparam upc_t S_FETCH       = 5'd2;
  localparam upc_t S_D_READ      = 5'd3;
  localparam upc_t S_D_BS        = 5'd4;
  localparam upc_t S_D_TAB       = 5'd5;
  localparam upc_t S_D_LF        = 5'd6;
  localparam upc_t S_D_FF        = 5'd7;
  localparam upc_t S_D_CR        = 5'd8;
  localparam upc_t S_D_GLYPH     = 5'd9;
  localparam upc_t S_GLYPH_DONE  = 5'd10;
  localparam upc_t S_RD_CAPTURE  = 5'd11;
  localparam upc_t S_TAB_SET     = 5'd12;
  localparam upc_t S_NEWLINE     = 5'd13;
  localparam upc_t S_SCROLL_INIT = 5'd14;
  localparam upc_t S_FILL        = 5'd15;
  localparam upc_t S_FINISH      = 5'd16;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    logic stall;
    logic sweep_more;
    logic tab_fits;
    logic col_wrap;
    logic row_not_last;
    cls_t cls;
  } seq_status_t;

  function automatic uword_t uw(act_t a, cond_t c, upc_t t);
    uword_t w;
    w.act    = a;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // A taken condition jumps to the target, otherwise the step counter
  // advances by one. A failed tab falls into the line-feed entry on purpose.
  function automatic uword_t ucode_rom(upc_t step);
    uword_t w;
    case (step)
      S_RST_INIT:    w = uw(ACT_RESET_INIT,  COND_NONE,         S_RST_FILL);
      S_RST_FILL:    w = uw(ACT_FILL,        COND_SWEEP_MORE,   S_RST_FILL);
      S_FETCH:       w = uw(ACT_TAKE,        COND_DISPATCH,     S_D_READ);
      S_D_READ:      w = uw(ACT_RD_ISSUE,    COND_ALWAYS,       S_RD_CAPTURE);
      S_D_BS:        w = uw(ACT_BS,          COND_ALWAYS,       S_FINISH);
      S_D_TAB:       w = uw(ACT_NONE,        COND_TAB_FITS,     S_TAB_SET);
      S_D_LF:        w = uw(ACT_NONE,        COND_ALWAYS,       S_NEWLINE);
      S_D_FF:        w = uw(ACT_FF_INIT,     COND_ALWAYS,       S_FILL);
      S_D_CR:        w = uw(ACT_CR,          COND_ALWAYS,       S_FINISH);
      S_D_GLYPH:     w = uw(ACT_GLYPH,       COND_COL_WRAP,     S_NEWLINE);
      S_GLYPH_DONE:  w = uw(ACT_NONE,        COND_ALWAYS,       S_FINISH);
      S_RD_CAPTURE:  w = uw(ACT_RD_CAPTURE,  COND_ALWAYS,       S_FINISH);
      S_TAB_SET:     w = uw(ACT_TAB_SET,     COND_ALWAYS,       S_FINISH);
      S_NEWLINE:     w = uw(ACT_LINE_DOWN,   COND_ROW_NOT_LAST, S_FINISH);
      S_SCROLL_INIT: w = uw(ACT_SCROLL_INIT, COND_NONE,         S_FILL);
      S_FILL:        w = uw(ACT_FILL,        COND_SWEEP_MORE,   S_FILL);
      S_FINISH:      w = uw(ACT_EMIT,        COND_ALWAYS,       S_FETCH);
      default:       w = uw(ACT_NONE,        COND_ALWAYS,       S_FETCH);
    endcase
    return w;
  endfunction

  function automatic cls_t classify(logic cmd, logic [CHAR_W-1:0] code);
    cls_t c;
    if (cmd == CMD_READ) begin
      c = CLS_READ;
    end else begin
      case (code)
        CH_BS:   c = CLS_BS;
        CH_HT:   c = CLS_TAB;
        CH_LF:   c = CLS_LF;
        CH_FF:   c = CLS_FF;
        CH_CR:   c = CLS_CR;
        default: c = CLS_GLYPH;
      endcase
    end
    return c;
  endfunction

endpackage

// ===== hdl/tmcw_screen_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Text console writer: screen store
// Single-port-write, single-port-read cell memory with a registered read.
// ---------------------------------------------------------------------------
module tmcw_screen_ram #(
  parameter int AW    = 12,
  parameter int DEPTH = tmcw_pkg::DEF_ROWS * (2 ** $clog2(tmcw_pkg::DEF_COLUMNS))
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [tmcw_pkg::CELL_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [tmcw_pkg::CELL_W-1:0] rdata
);
  import tmcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/tmcw_seq.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Text console writer: microcode sequencer
// Step counter over the control store, with conditional and dispatch jumps.
// ---------------------------------------------------------------------------
module tmcw_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tmcw_pkg::seq_status_t status,
  output tmcw_pkg::act_t        act
);
  import tmcw_pkg::*;

  upc_t   upc_r, upc_nxt;
  uword_t word;
  logic   jump;

  always_comb word = ucode_rom(upc_r);
  assign act = word.act;

  always_comb begin
    case (word.cond)
      COND_NONE:         jump = 1'b0;
      COND_ALWAYS:       jump = 1'b1;
      COND_SWEEP_MORE:   jump = status.sweep_more;
      COND_DISPATCH:     jump = 1'b1;
      COND_TAB_FITS:     jump = status.tab_fits;
      COND_COL_WRAP:     jump = status.col_wrap;
      COND_ROW_NOT_LAST: jump = status.row_not_last;
      default:           jump = 1'b0;
    endcase
  end

  always_comb begin
    if (status.stall) begin
      upc_nxt = upc_r;
    end else if (jump && word.cond == COND_DISPATCH) begin
      upc_nxt = word.target + upc_t'(status.cls);
    end else if (jump) begin
      upc_nxt = word.target;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_RST_INIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // The step counter never leaves the program.
  a_upc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r <= S_FINISH)
    else $error("step counter outside the program");

  // A beat taken at fetch lands in the dispatch table.
  a_dispatch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == S_FETCH && !status.stall) |=> (upc_r >= S_D_READ && upc_r <= S_D_GLYPH))
    else $error("dispatch left the table");

  // A delivered result always returns the sequencer to fetch.
  a_finish_to_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == S_FINISH && !status.stall) |=> upc_r == S_FETCH)
    else $error("finish did not return to fetch");

endmodule

// ===== hdl/text_mode_console_writer_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Text console writer core
// A text console: characters are written at a cursor into a screen store,
// with wrap, scroll, tab, backspace, line feed, form feed and cell read-back.
// ---------------------------------------------------------------------------
// Items are taken one at a time: the next beat is taken only after the result
// of the last has been emitted, and emit waits while an earlier result is held.
// A scroll adds a sweep of one row of COLUMNS cells and a form feed a sweep
// of all ROWS * COLUMNS cells, both set by the single write port of the
// screen store, swept one cell a cycle.
// After reset a clearing pass over all ROWS * COLUMNS cells runs before
// the first beat is taken; configuration writes are taken throughout.
module text_mode_console_writer_core #(
  parameter int COLUMNS  = tmcw_pkg::DEF_COLUMNS,
  parameter int ROWS     = tmcw_pkg::DEF_ROWS,
  parameter int TAB_STEP = tmcw_pkg::DEF_TAB_STEP
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata: char_code[7:0], read_row[12:8], read_col[19:13], zero fill above
  input  logic [tmcw_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: cmd[0]
  input  logic [0:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata: cell_data[15:0], cursor_row[20:16], cursor_col[27:21], zero fill above
  output logic [tmcw_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tmcw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tmcw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tmcw_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS * (2 ** CW);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

  // Tab stops: the next multiple of TAB_STEP for every column.
  logic [CW-1:0] tab_next [2 ** CW];
  logic          tab_fit_tbl [2 ** CW];

  for (genvar g = 0; g < 2 ** CW; g++) begin : g_tab
    localparam int Stop = (g / TAB_STEP + 1) * TAB_STEP;
    assign tab_next[g]    = CW'(Stop);
    assign tab_fit_tbl[g] = (Stop < COLUMNS);
  end

  // Scrolling rotates the row base instead of moving cells.
  function automatic logic [RW-1:0] phys_row(logic [RW-1:0] lr, logic [RW-1:0] b);
    logic [RW:0] s;
    s = {1'b0, lr} + {1'b0, b};
    if (s >= (RW + 1)'(ROWS)) begin
      s = s - (RW + 1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  act_t        act;
  seq_status_t status;

  logic [CHAR_W-1:0]      in_char;
  logic [ROW_FIELD_W-1:0] in_rrow;
  logic [COL_FIELD_W-1:0] in_rcol;

  logic [TEXT_W-1:0]  text_color_r;
  logic [BACK_W-1:0]  back_color_r;
  logic [RW-1:0]      cur_row_r, cur_row_nxt;
  logic [CW-1:0]      cur_col_r, cur_col_nxt;
  logic [RW-1:0]      base_r, base_nxt;
  logic [RW-1:0]      sweep_row_r, sweep_row_nxt;
  logic [CW-1:0]      sweep_col_r, sweep_col_nxt;
  logic               sweep_all_r, sweep_all_nxt;
  logic [CELL_W-1:0]  fill_r, fill_nxt;
  logic [CHAR_W-1:0]  char_r, char_nxt;
  logic [RW-1:0]      rrow_r, rrow_nxt;
  logic [CW-1:0]      rcol_r, rcol_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic [CELL_W-1:0]  data_r, data_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0]      out_data_r, out_data_nxt;
  logic [ROW_FIELD_W-1:0] out_row_r, out_row_nxt;
  logic [COL_FIELD_W-1:0] out_col_r, out_col_nxt;

  logic [CELL_W-1:0] glyph_word;
  logic [CELL_W-1:0] blank_word;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  assign in_char = in_tdata[7:0];
  assign in_rrow = in_tdata[12:8];
  assign in_rcol = in_tdata[19:13];

  assign in_tready  = (act == ACT_TAKE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - CELL_W - ROW_FIELD_W - COL_FIELD_W)'(0),
                       out_col_r, out_row_r, out_data_r};
  assign cfg_ready  = 1'b1;

  assign glyph_word = {1'b0, back_color_r, text_color_r, char_r};
  assign blank_word = {1'b0, back_color_r, text_color_r, CH_SPACE};

  always_comb begin
    status.stall        = (act == ACT_TAKE && !in_tvalid) ||
                          (act == ACT_EMIT && out_valid_r && !out_tready);
    status.sweep_more   = !(sweep_col_r == COL_LAST &&
                            (!sweep_all_r || sweep_row_r == ROW_LAST));
    status.tab_fits     = tab_fit_tbl[cur_col_r];
    status.col_wrap     = (cur_col_r == COL_LAST);
    status.row_not_last = (cur_row_r != ROW_LAST);
    status.cls          = classify(in_tuser[0], in_char);
  end

  tmcw_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .act    (act)
  );

  tmcw_screen_ram #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    base_nxt      = base_r;
    sweep_row_nxt = sweep_row_r;
    sweep_col_nxt = sweep_col_r;
    sweep_all_nxt = sweep_all_r;
    fill_nxt      = fill_r;
    char_nxt      = char_r;
    rrow_nxt      = rrow_r;
    rcol_nxt      = rcol_r;
    rd_ok_nxt     = rd_ok_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    ram_we        = 1'b0;
    ram_waddr     = {sweep_row_r, sweep_col_r};
    ram_wdata     = fill_r;
    ram_re        = 1'b0;
    ram_raddr     = {phys_row(rrow_r, base_r), rcol_r};

    case (act)
      ACT_RESET_INIT: begin
        sweep_row_nxt = '0;
        sweep_col_nxt = '0;
        sweep_all_nxt = 1'b1;
        fill_nxt      = CELL_RESET;
      end
      ACT_FILL: begin
        ram_we = 1'b1;
        if (sweep_col_r == COL_LAST) begin
          sweep_col_nxt = '0;
          sweep_row_nxt = sweep_row_r + 1'b1;
        end else begin
          sweep_col_nxt = sweep_col_r + 1'b1;
        end
      end
      ACT_TAKE: begin
        if (in_tvalid) begin
          char_nxt  = in_char;
          rrow_nxt  = RW'(in_rrow);
          rcol_nxt  = CW'(in_rcol);
          rd_ok_nxt = (int'(in_rrow) < ROWS) && (int'(in_rcol) < COLUMNS);
          data_nxt  = '0;
        end
      end
      ACT_RD_ISSUE: begin
        ram_re = 1'b1;
      end
      ACT_RD_CAPTURE: begin
        data_nxt = rd_ok_r ? ram_rdata : '0;
      end
      ACT_BS: begin
        if (cur_col_r != '0) begin
          cur_col_nxt = cur_col_r - 1'b1;
        end
      end
      ACT_CR: begin
        cur_col_nxt = '0;
      end
      ACT_TAB_SET: begin
        cur_col_nxt = tab_next[cur_col_r];
      end
      ACT_GLYPH: begin
        ram_we    = 1'b1;
        ram_waddr = {phys_row(cur_row_r, base_r), cur_col_r};
        ram_wdata = glyph_word;
        data_nxt  = glyph_word;
        if (cur_col_r != COL_LAST) begin
          cur_col_nxt = cur_col_r + 1'b1;
        end
      end
      ACT_LINE_DOWN: begin
        cur_col_nxt = '0;
        if (cur_row_r != ROW_LAST) begin
          cur_row_nxt = cur_row_r + 1'b1;
        end
      end
      ACT_SCROLL_INIT: begin
        // The old top row becomes the new bottom row and is blanked.
        sweep_row_nxt = base_r;
        sweep_col_nxt = '0;
        sweep_all_nxt = 1'b0;
        fill_nxt      = blank_word;
        base_nxt      = (base_r == ROW_LAST) ? '0 : base_r + 1'b1;
      end
      ACT_FF_INIT: begin
        sweep_row_nxt = '0;
        sweep_col_nxt = '0;
        sweep_all_nxt = 1'b1;
        fill_nxt      = blank_word;
        base_nxt      = '0;
        cur_row_nxt   = '0;
        cur_col_nxt   = '0;
      end
      ACT_EMIT: begin
        if (!status.stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_r;
          out_row_nxt   = ROW_FIELD_W'(cur_row_r);
          out_col_nxt   = COL_FIELD_W'(cur_col_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= TEXT_RESET;
      back_color_r <= BACK_RESET;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      base_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TEXT_COLOR: text_color_r <= cfg_data[TEXT_W-1:0];
          CFG_BACK_COLOR: back_color_r <= cfg_data[BACK_W-1:0];
          default: begin
          end
        endcase
      end
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sweep_row_r <= sweep_row_nxt;
    sweep_col_r <= sweep_col_nxt;
    sweep_all_r <= sweep_all_nxt;
    fill_r      <= fill_nxt;
    char_r      <= char_nxt;
    rrow_r      <= rrow_nxt;
    rcol_r      <= rcol_nxt;
    rd_ok_r     <= rd_ok_nxt;
    data_r      <= data_nxt;
    out_data_r  <= out_data_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
  end

  // The cursor always stays on the screen.
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    cur_row_r <= ROW_LAST && cur_col_r <= COL_LAST)
    else $error("cursor left the screen");

  // The row base is always a real row.
  a_base_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    base_r <= ROW_LAST)
    else $error("row base out of range");

  // Every store write lands on a visible column.
  a_write_in_columns: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ram_waddr[CW-1:0] <= COL_LAST)
    else $error("screen write beyond the last column");

endmodule
